[rtl/usms_pkg.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator package
// Shared constants and types: register indexes, item kinds, sine series.
// ----------------------------------------------------------------------------
package usms_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned IDX_W = 16;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [7:0] MAX_DIVISIONS = 8'd255;
  localparam logic [7:0] MIN_DIVISIONS = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd2;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_CELL   = 1'b1
  } kind_e;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  localparam int unsigned TAYLOR_TERMS = 5;
  localparam logic [7:0] TAYLOR_DIV [TAYLOR_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  // floor(2^32 / divisor)
  localparam logic [29:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
    30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882
  };

  localparam int unsigned SINE_STAGES = 3 + 3 * TAYLOR_TERMS + 2;

endpackage

[rtl/uv_sphere_mesh_generator_unit.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator
// Vertex positions and cell triangles of a latitude-longitude sphere.
// ----------------------------------------------------------------------------
// Input channel: kind, row, column with valid/stall; a vertex word gives one
// result, a cell word in range gives two triangles on the output channel.
// Configuration: radius, stack and slice counts through a plain write port;
// write only while no word is in flight.
// Structure: an entry register, a one-bit-per-stage angle divider, a 20-stage
// sine series, three product stages and the output register. Throughput: one
// vertex word per cycle while the output is not stalled; a cell word in range
// holds the output until both of its triangles are taken.
// The pipeline advances on one shared enable; while the output is stalled it
// still moves if its last stage is empty, so bubbles fill up.
// Reset: registers return to radius 1.0, three stacks, three slices; the
// pipeline and output come up empty.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator_unit #(
  parameter int unsigned AngleBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_write_i,
  input  logic [usms_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [usms_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [7:0]                     row_i,
  input  logic [7:0]                     column_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [usms_pkg::POS_W-1:0] pos_x_o,
  output logic signed [usms_pkg::POS_W-1:0] pos_y_o,
  output logic signed [usms_pkg::POS_W-1:0] pos_z_o,
  output logic [usms_pkg::IDX_W-1:0]     corner_a_o,
  output logic [usms_pkg::IDX_W-1:0]     corner_b_o,
  output logic [usms_pkg::IDX_W-1:0]     corner_c_o,
  output logic                           last_of_run_o,
  output logic                           bad_coordinate_o
);
  import usms_pkg::*;

  localparam int unsigned DivW = AngleBits + 9;
  localparam int unsigned SinEnd = DivW + SINE_STAGES;
  localparam int unsigned NStg = SinEnd + 4;

  typedef struct packed {
    logic             kind;
    logic             bad;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
  } meta_t;

  logic [15:0] radius_q;
  logic [7:0]  stack_q, slice_q;
  logic [7:0]  stacks, slices;
  logic [8:0]  dvs_phi, dvs_th;

  logic            en, out_load, out_last;
  logic [NStg-1:0] vld_q;
  meta_t           meta_d;
  meta_t           meta_q [NStg];
  logic [16:0]     first_full;

  logic [DivW-1:0] phi_num_q [0:DivW];
  logic [DivW-1:0] th_num_q  [0:DivW];
  logic [8:0]      phi_rem_q [1:DivW];
  logic [8:0]      th_rem_q  [1:DivW];

  logic [AngleBits-1:0] phi, theta, phi_c, theta_c;
  logic signed [POS_W-1:0] sin_phi, cos_phi, sin_th, cos_th;
  logic [14:0] mag_sp, mag_cp, mag_st, mag_ct;

  logic [30:0] rs_q, rc_q;
  logic [14:0] ct_q, st_q;
  logic        sx1_q, sz1_q, sy1_q;
  logic [45:0] mx_q, mz_q;
  logic        sx2_q, sz2_q;
  logic signed [POS_W-1:0] y2_q;
  logic [15:0] yr, xr, zr;
  logic [45:0] xr_sum, zr_sum;
  logic signed [POS_W-1:0] px3_q, py3_q, pz3_q;

  logic        out_v_q, phase_q;
  meta_t       out_meta_q;
  logic signed [POS_W-1:0] out_x_q, out_y_q, out_z_q;
  logic        cell_ok;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      stack_q  <= 8'd3;
      slice_q  <= 8'd3;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_STACKS: stack_q  <= cfg_data_i[7:0];
        REG_SLICES: slice_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign stacks = (stack_q < MIN_DIVISIONS) ? MIN_DIVISIONS :
                  (stack_q > MAX_DIVISIONS) ? MAX_DIVISIONS : stack_q;
  assign slices = (slice_q < MIN_DIVISIONS) ? MIN_DIVISIONS :
                  (slice_q > MAX_DIVISIONS) ? MAX_DIVISIONS : slice_q;
  assign dvs_phi = {stacks, 1'b0};
  assign dvs_th  = {slices, 1'b0};

  // pipeline control
  assign out_load   = !out_v_q || (!out_stall_i && out_last);
  assign en         = out_load || !vld_q[NStg-1];
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // index and range check at entry
  assign first_full = 17'(row_i) * 17'({1'b0, slices} + 9'd1) + 17'(column_i);

  always_comb begin
    meta_d.kind   = kind_i;
    meta_d.first  = first_full[IDX_W-1:0];
    meta_d.second = first_full[IDX_W-1:0] + IDX_W'(slices) + IDX_W'(1);
    if (kind_i == KIND_CELL) begin
      meta_d.bad = (row_i >= stacks) || (column_i >= slices);
    end else begin
      meta_d.bad = (row_i > stacks) || (column_i > slices);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0]    <= meta_d;
      phi_num_q[0] <= (DivW'(row_i) << AngleBits) + DivW'(stacks);
      th_num_q[0]  <= (DivW'(column_i) << (AngleBits + 1)) + DivW'(slices);
      for (int k = 1; k < NStg; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // restoring dividers, one quotient bit per stage
  for (genvar k = 1; k <= DivW; k++) begin : g_div
    logic [9:0] cand_p, cand_t;
    logic       ge_p, ge_t;
    if (k == 1) begin : g_head
      assign cand_p = {9'd0, phi_num_q[0][DivW-1]};
      assign cand_t = {9'd0, th_num_q[0][DivW-1]};
    end else begin : g_body
      assign cand_p = {phi_rem_q[k-1], phi_num_q[k-1][DivW-1]};
      assign cand_t = {th_rem_q[k-1], th_num_q[k-1][DivW-1]};
    end
    assign ge_p = cand_p >= {1'b0, dvs_phi};
    assign ge_t = cand_t >= {1'b0, dvs_th};
    always_ff @(posedge clk_i) begin
      if (en) begin
        phi_rem_q[k] <= ge_p ? 9'(cand_p - {1'b0, dvs_phi}) : cand_p[8:0];
        th_rem_q[k]  <= ge_t ? 9'(cand_t - {1'b0, dvs_th}) : cand_t[8:0];
        phi_num_q[k] <= {phi_num_q[k-1][DivW-2:0], ge_p};
        th_num_q[k]  <= {th_num_q[k-1][DivW-2:0], ge_t};
      end
    end
  end

  assign phi     = phi_num_q[DivW][AngleBits-1:0];
  assign theta   = th_num_q[DivW][AngleBits-1:0];
  assign phi_c   = phi + (AngleBits'(1) << (AngleBits - 2));
  assign theta_c = theta + (AngleBits'(1) << (AngleBits - 2));

  usms_sine #(.AngleBits(AngleBits)) u_sin_phi (
    .clk_i(clk_i), .en_i(en), .angle_i(phi), .sine_o(sin_phi));
  usms_sine #(.AngleBits(AngleBits)) u_cos_phi (
    .clk_i(clk_i), .en_i(en), .angle_i(phi_c), .sine_o(cos_phi));
  usms_sine #(.AngleBits(AngleBits)) u_sin_th (
    .clk_i(clk_i), .en_i(en), .angle_i(theta), .sine_o(sin_th));
  usms_sine #(.AngleBits(AngleBits)) u_cos_th (
    .clk_i(clk_i), .en_i(en), .angle_i(theta_c), .sine_o(cos_th));

  assign mag_sp = sin_phi[POS_W-1] ? 15'(-sin_phi) : sin_phi[14:0];
  assign mag_cp = cos_phi[POS_W-1] ? 15'(-cos_phi) : cos_phi[14:0];
  assign mag_st = sin_th[POS_W-1]  ? 15'(-sin_th)  : sin_th[14:0];
  assign mag_ct = cos_th[POS_W-1]  ? 15'(-cos_th)  : cos_th[14:0];

  assign yr     = 16'((32'(rc_q) + 32'h4000) >> 15);
  assign xr_sum = mx_q + 46'(32'h2000_0000);
  assign zr_sum = mz_q + 46'(32'h2000_0000);
  assign xr     = xr_sum[30 +: 16];
  assign zr     = zr_sum[30 +: 16];

  // scale by radius, round half away from zero; cell and bad words get zeros
  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q  <= 31'(radius_q) * 31'(mag_sp);
      rc_q  <= 31'(radius_q) * 31'(mag_cp);
      ct_q  <= mag_ct;
      st_q  <= mag_st;
      sx1_q <= sin_phi[POS_W-1] ^ cos_th[POS_W-1];
      sz1_q <= sin_phi[POS_W-1] ^ sin_th[POS_W-1];
      sy1_q <= cos_phi[POS_W-1];

      mx_q  <= 46'(rs_q) * 46'(ct_q);
      mz_q  <= 46'(rs_q) * 46'(st_q);
      sx2_q <= sx1_q;
      sz2_q <= sz1_q;
      y2_q  <= sy1_q ? -$signed({1'b0, yr}) : $signed({1'b0, yr});

      if (meta_q[NStg-2].kind == KIND_CELL || meta_q[NStg-2].bad) begin
        px3_q <= '0;
        py3_q <= '0;
        pz3_q <= '0;
      end else begin
        px3_q <= sx2_q ? -$signed({1'b0, xr}) : $signed({1'b0, xr});
        py3_q <= y2_q;
        pz3_q <= sz2_q ? -$signed({1'b0, zr}) : $signed({1'b0, zr});
      end
    end
  end

  // output register
  assign cell_ok  = (out_meta_q.kind == KIND_CELL) && !out_meta_q.bad;
  assign out_last = !cell_ok || phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= vld_q[NStg-1];
      phase_q <= 1'b0;
    end else if (!out_stall_i) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_meta_q <= meta_q[NStg-1];
      out_x_q    <= px3_q;
      out_y_q    <= py3_q;
      out_z_q    <= pz3_q;
    end
  end

  assign out_valid_o      = out_v_q;
  assign pos_x_o          = out_x_q;
  assign pos_y_o          = out_y_q;
  assign pos_z_o          = out_z_q;
  assign corner_a_o       = !cell_ok ? '0 :
                            phase_q ? out_meta_q.first + IDX_W'(1) : out_meta_q.first;
  assign corner_b_o       = cell_ok ? out_meta_q.second : '0;
  assign corner_c_o       = !cell_ok ? '0 :
                            phase_q ? out_meta_q.second + IDX_W'(1)
                                    : out_meta_q.first + IDX_W'(1);
  assign last_of_run_o    = out_last;
  assign bad_coordinate_o = out_meta_q.bad;

endmodule

[rtl/usms_sine.sv]
// ----------------------------------------------------------------------------
// Pipelined sine of a turn fraction
// Quadrant fold, fixed-point Taylor series in Q2.30, rounded Q1.15 result.
// ----------------------------------------------------------------------------
module usms_sine #(
  parameter int unsigned AngleBits = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [AngleBits-1:0]        angle_i,
  output logic signed [usms_pkg::POS_W-1:0] sine_o
);
  import usms_pkg::*;

  localparam int unsigned FracW = AngleBits - 2;
  localparam int unsigned ProdW = AngleBits + 30;
  localparam logic [AngleBits-2:0] QTurn = (AngleBits-1)'(1) << FracW;
  localparam logic [ProdW-1:0] RoundA = ProdW'(1) << (AngleBits - 3);
  localparam int unsigned LastX = 2 + 3 * TAYLOR_TERMS;
  localparam int unsigned LastX2 = 2 + 3 * (TAYLOR_TERMS - 1);

  logic [AngleBits-2:0] fold_d, fold_q;
  logic                 neg_q [0:LastX+1];
  logic [30:0]          x_q   [1:LastX];
  logic [31:0]          x2_q  [2:LastX2];
  logic [ProdW-1:0]     ang_prod;
  logic [61:0]          sq;
  logic [31:0]          tp_q [TAYLOR_TERMS];
  logic [29:0]          tq_q [TAYLOR_TERMS];
  logic [31:0]          tr_q [TAYLOR_TERMS];
  logic [30:0]          tt_q [TAYLOR_TERMS];
  logic [61:0]          s_prod;
  logic [30:0]          s_q;
  logic [16:0]          s_rnd;
  logic [14:0]          s_sat;
  logic signed [POS_W-1:0] sine_q;

  assign fold_d = angle_i[AngleBits-2] ? QTurn - {1'b0, angle_i[FracW-1:0]}
                                       : {1'b0, angle_i[FracW-1:0]};
  assign ang_prod = ProdW'(fold_q) * ProdW'(HALF_PI_Q30) + RoundA;
  assign sq = 62'(x_q[1]) * 62'(x_q[1]) + 62'(32'h2000_0000);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fold_q   <= fold_d;
      neg_q[0] <= angle_i[AngleBits-1];
      x_q[1]   <= ang_prod[FracW +: 31];
      x2_q[2]  <= sq[30 +: 32];
      for (int k = 1; k <= LastX + 1; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
      for (int k = 2; k <= LastX; k++) begin
        x_q[k] <= x_q[k-1];
      end
      for (int k = 3; k <= LastX2; k++) begin
        x2_q[k] <= x2_q[k-1];
      end
    end
  end

  for (genvar i = 0; i < TAYLOR_TERMS; i++) begin : g_term
    logic [30:0] t_in;
    logic [62:0] pa;
    logic [61:0] pb;
    logic [31:0] rem;
    logic [31:0] dq;
    if (i == 0) begin : g_first
      assign t_in = Q30_ONE;
    end else begin : g_next
      assign t_in = tt_q[i-1];
    end
    assign pa  = 63'(x2_q[2+3*i]) * 63'(t_in);
    assign pb  = 62'(tp_q[i]) * 62'(TAYLOR_RECIP[i]);
    assign rem = tr_q[i] - 32'(tq_q[i]) * 32'(TAYLOR_DIV[i]);
    assign dq  = (rem >= 32'(TAYLOR_DIV[i])) ? 32'(tq_q[i]) + 32'd1 : 32'(tq_q[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tp_q[i] <= pa[30 +: 32];
        tq_q[i] <= pb[32 +: 30];
        tr_q[i] <= tp_q[i];
        tt_q[i] <= (dq >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - dq);
      end
    end
  end

  assign s_prod = 62'(x_q[LastX]) * 62'(tt_q[TAYLOR_TERMS-1]);
  assign s_rnd  = 17'((32'(s_q) + 32'h4000) >> 15);
  assign s_sat  = (s_rnd > 17'd32767) ? 15'h7FFF : s_rnd[14:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_prod[30 +: 31];
      sine_q <= neg_q[LastX+1] ? -$signed({2'b00, s_sat}) : $signed({2'b00, s_sat});
    end
  end

  assign sine_o = sine_q;

endmodule

[rtl/usms_checker.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module usms_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_stall_i,
  input logic signed [usms_pkg::POS_W-1:0] pos_x_i,
  input logic signed [usms_pkg::POS_W-1:0] pos_y_i,
  input logic signed [usms_pkg::POS_W-1:0] pos_z_i,
  input logic [usms_pkg::IDX_W-1:0]     corner_a_i,
  input logic [usms_pkg::IDX_W-1:0]     corner_b_i,
  input logic [usms_pkg::IDX_W-1:0]     corner_c_i,
  input logic                           last_of_run_i,
  input logic                           bad_coordinate_i
);
  import usms_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result word dropped under stall");

  a_bad_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_coordinate_i |-> last_of_run_i && pos_x_i == 0 &&
      pos_y_i == 0 && pos_z_i == 0 && corner_a_i == 0 && corner_b_i == 0 &&
      corner_c_i == 0)
    else $error("bad coordinate word carries data");

  a_first_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> !bad_coordinate_i && pos_x_i == 0 &&
      pos_y_i == 0 && pos_z_i == 0)
    else $error("first triangle word malformed");

  a_tri_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !last_of_run_i |=> out_valid_i &&
      last_of_run_i && corner_a_i == $past(corner_c_i) &&
      corner_b_i == $past(corner_b_i))
    else $error("second triangle does not follow first");

endmodule

bind uv_sphere_mesh_generator_unit usms_checker u_usms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .pos_x_i         (pos_x_o),
  .pos_y_i         (pos_y_o),
  .pos_z_i         (pos_z_o),
  .corner_a_i      (corner_a_o),
  .corner_b_i      (corner_b_o),
  .corner_c_i      (corner_c_o),
  .last_of_run_i   (last_of_run_o),
  .bad_coordinate_i(bad_coordinate_o)
);

[verif/uv_sphere_mesh_generator_unit_test.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator unit test
// Streams vertex and cell words through the block under several radius,
// stack and slice settings with random idling on both sides, predicts every
// result in fixed point and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator_unit_test;
  import usms_pkg::*;

  localparam int unsigned ABITS = 16;
  localparam longint unsigned QTURN = 64'd1 << (ABITS - 2);
  localparam longint unsigned AMASK = (64'd1 << ABITS) - 1;
  localparam int unsigned LIMIT = 600000;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] row;
    logic [7:0] column;
  } mesh_word_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             last;
    logic             bad;
  } mesh_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_write_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i = 1'b0;
  logic [7:0]           row_i = '0;
  logic [7:0]           column_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic [IDX_W-1:0]     corner_a_o, corner_b_o, corner_c_o;
  logic                 last_of_run_o, bad_coordinate_o;

  logic [15:0] radius_q = 16'd256;
  logic [7:0]  stacks_q = 8'd3;
  logic [7:0]  slices_q = 8'd3;

  mesh_word_t   pending_words[$];
  mesh_result_t expected_results[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  results_seen = 0;
  bit           quiet = 1'b0;
  bit           long_hold_done = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_gap = 0;

  uv_sphere_mesh_generator_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned eff_div(logic [7:0] v);
    return (v < MIN_DIVISIONS) ? 64'd3 : 64'(v);
  endfunction

  function automatic longint quarter_sin(longint unsigned a);
    longint unsigned dv[5] = '{110, 72, 42, 20, 6};
    longint unsigned x, x2, t, d, s;
    x = (a * 64'd1686629713 + (QTURN >> 1)) >> (ABITS - 2);
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 5; i++) begin
      d = ((x2 * t) >> 30) / dv[i];
      t = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
    end
    s = (x * t) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint turn_sin(longint unsigned ang);
    longint unsigned q, f;
    longint v;
    ang &= AMASK;
    q = ang >> (ABITS - 2);
    f = ang & (QTURN - 1);
    v = q[0] ? quarter_sin(QTURN - f) : quarter_sin(f);
    return q[1] ? -v : v;
  endfunction

  function automatic logic [POS_W-1:0] round_q(longint v, int unsigned sh);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? POS_W'(-longint'(m)) : POS_W'(m);
  endfunction

  task automatic predict_mesh(mesh_word_t w);
    longint unsigned st, sl, phi, theta, first, second;
    longint r, sp, cp, s_t, c_t;
    mesh_result_t e;
    st = eff_div(stacks_q);
    sl = eff_div(slices_q);
    r = longint'(radius_q);
    e = '0;
    if (w.kind == KIND_VERTEX) begin
      e.last = 1'b1;
      if (w.row > st || w.column > sl) begin
        e.bad = 1'b1;
      end else begin
        phi = ((64'(w.row) << ABITS) + st) / (2 * st);
        theta = ((64'(w.column) << (ABITS + 1)) + sl) / (2 * sl);
        sp = turn_sin(phi);
        cp = turn_sin(phi + QTURN);
        s_t = turn_sin(theta);
        c_t = turn_sin(theta + QTURN);
        e.x = round_q(r * sp * c_t, 30);
        e.y = round_q(r * cp, 15);
        e.z = round_q(r * sp * s_t, 30);
      end
      expected_results.push_back(e);
    end else if (w.row >= st || w.column >= sl) begin
      e.last = 1'b1;
      e.bad = 1'b1;
      expected_results.push_back(e);
    end else begin
      first = 64'(w.row) * (sl + 1) + w.column;
      second = first + sl + 1;
      e.a = IDX_W'(first);
      e.b = IDX_W'(second);
      e.c = IDX_W'(first + 1);
      expected_results.push_back(e);
      e.a = IDX_W'(first + 1);
      e.c = IDX_W'(second + 1);
      e.last = 1'b1;
      expected_results.push_back(e);
    end
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_mesh(pending_words.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        kind_i <= pending_words[0].kind;
        row_i <= pending_words[0].row;
        column_i <= pending_words[0].column;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mesh_result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("out_valid", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (pos_x_o !== e.x) report_mismatch("pos_x", pos_x_o, e.x);
          if (pos_y_o !== e.y) report_mismatch("pos_y", pos_y_o, e.y);
          if (pos_z_o !== e.z) report_mismatch("pos_z", pos_z_o, e.z);
          if (corner_a_o !== e.a) report_mismatch("corner_a", corner_a_o, e.a);
          if (corner_b_o !== e.b) report_mismatch("corner_b", corner_b_o, e.b);
          if (corner_c_o !== e.c) report_mismatch("corner_c", corner_c_o, e.c);
          if (last_of_run_o !== e.last)
            report_mismatch("last_of_run", last_of_run_o, e.last);
          if (bad_coordinate_o !== e.bad)
            report_mismatch("bad_coordinate", bad_coordinate_o, e.bad);
        end
      end
      if (!long_hold_done && results_seen >= 100) begin
        long_hold_done <= 1'b1;
        recv_gap <= 400;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_write_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_RADIUS: radius_q = val;
      REG_STACKS: stacks_q = val[7:0];
      REG_SLICES: slices_q = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_write_i <= 1'b0;
  endtask

  task automatic add_word(kind_e k, int unsigned r, int unsigned c);
    mesh_word_t w;
    w.kind = k;
    w.row = 8'(r);
    w.column = 8'(c);
    pending_words.push_back(w);
  endtask

  task automatic run_phase(logic [15:0] rad, logic [15:0] st, logic [15:0] sl, int n);
    int unsigned s, c;
    write_reg(REG_RADIUS, rad);
    write_reg(REG_STACKS, st);
    write_reg(REG_SLICES, sl);
    write_reg(2'd3, 16'($urandom));
    s = 32'(eff_div(stacks_q));
    c = 32'(eff_div(slices_q));
    add_word(KIND_VERTEX, 0, 0);
    add_word(KIND_VERTEX, s, c);
    add_word(KIND_VERTEX, s / 2, c / 4);
    add_word(KIND_VERTEX, s + 1, 0);
    add_word(KIND_VERTEX, 0, c + 1);
    add_word(KIND_VERTEX, 255, 255);
    add_word(KIND_CELL, 0, 0);
    add_word(KIND_CELL, s - 1, c - 1);
    add_word(KIND_CELL, s, 0);
    add_word(KIND_CELL, 0, c);
    add_word(KIND_CELL, 255, 255);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_word(kind_e'($urandom_range(0, 1)), $urandom_range(0, 255),
                 $urandom_range(0, 255));
      else
        add_word(kind_e'($urandom_range(0, 1)), $urandom_range(0, s + 1),
                 $urandom_range(0, c + 1));
    end
    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(16'd256, 16'd3, 16'd3, 60);
    run_phase(16'hFFFF, 16'd255, 16'd255, 150);
    run_phase(16'd0, 16'd1, 16'h0102, 40);
    run_phase(16'($urandom), 16'($urandom_range(3, 20)), 16'($urandom_range(3, 20)), 150);
    run_phase(16'($urandom), 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 120);
    quiet = 1'b1;
    run_phase(16'd384, 16'd8, 16'd12, 80);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
